>>> rtl/core/fsd_pkg.sv
// shared types and constants for the frame sync deframer
package fsd_pkg;

	typedef enum logic [1:0] {
		CFG_HEADER_0 = 2'd0,
		CFG_HEADER_1 = 2'd1,
		CFG_FOOTER_0 = 2'd2,
		CFG_FOOTER_1 = 2'd3
	} cfg_idx_t;

	localparam int unsigned HDR_BYTES  = 14;
	localparam int unsigned TAIL_BYTES = 4;

	typedef struct packed {
		logic [31:0] seq;
		logic [63:0] ts;
		logic [31:0] drops;
	} frame_meta_t;

endpackage

>>> rtl/core/frame_sync_deframer.sv
// top level of the frame sync deframer
// Usage: bytes enter on in_valid/in_ready with rx_byte, one beat per byte.
// The front keeps a sliding window of PAYLOAD_BYTES+18 bytes and tests the
// header, footer and 16-bit additive checksum when the window is full, using
// running sums updated each beat.
// A good frame is latched into a one-frame hand-off register and the window
// empties; a bad window drops its oldest byte and bumps discarded_bytes
// (saturating). The back emits ceil(PAYLOAD_BYTES/8) beats on out_valid /
// out_ready, one chunk per cycle while out_ready is high.
// Throughput: one byte per cycle; the front stalls on any byte while a frame
// waits in the hand-off register because the back is still busy, which the
// frame length rules out unless the receiver holds out_ready low.
// Receiver stalls freeze the chunk outputs.
// Configuration: cfg_valid/cfg_ready with cfg_index (0,1 header bytes; 2,3
// footer bytes) and cfg_data, written while idle; always ready.
// Reset clears the window, fill, checksum, discard count and marks to 0.
module frame_sync_deframer #(
	parameter int unsigned PAYLOAD_BYTES = 72
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sequence_number,
	output logic [63:0] timestamp_ns,
	output logic [3:0]  chunk_index,
	output logic [63:0] payload_chunk,
	output logic        last_chunk,
	output logic [31:0] discarded_bytes
);
	import fsd_pkg::*;

	logic [7:0]                 hdr0_q, hdr1_q, ftr0_q, ftr1_q;
	logic                       frm_valid;
	logic                       frm_ready;
	frame_meta_t                frm_meta;
	logic [PAYLOAD_BYTES*8-1:0] frm_payload;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr0_q <= '0;
			hdr1_q <= '0;
			ftr0_q <= '0;
			ftr1_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HEADER_0: hdr0_q <= cfg_data;
				CFG_HEADER_1: hdr1_q <= cfg_data;
				CFG_FOOTER_0: ftr0_q <= cfg_data;
				CFG_FOOTER_1: ftr1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fsd_window #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_window (
		.clk, .arst_n, .in_valid, .in_ready, .rx_byte,
		.hdr0(hdr0_q), .hdr1(hdr1_q), .ftr0(ftr0_q), .ftr1(ftr1_q),
		.frm_valid, .frm_ready, .frm_meta, .frm_payload
	);

	fsd_chunker #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_chunker (
		.clk, .arst_n, .frm_valid, .frm_ready, .frm_meta, .frm_payload,
		.out_valid, .out_ready, .sequence_number, .timestamp_ns, .chunk_index,
		.payload_chunk, .last_chunk, .discarded_bytes
	);

	// a held chunk keeps its index
	a_hold_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chunk_index))
		else $error("chunk index moved under stall");

	// first chunk of a frame is index zero
	a_first_idx: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> chunk_index == 4'd0)
		else $error("frame did not start at chunk zero");

	// the last chunk closes the frame
	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_chunk |=> !out_valid || chunk_index == 4'd0)
		else $error("chunk after last without new frame");

endmodule

>>> rtl/core/fsd_window.sv
// front end: sliding byte window, running checksum and frame test
module fsd_window #(
	parameter int unsigned PAYLOAD_BYTES = 72
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	input  logic [7:0]                    hdr0,
	input  logic [7:0]                    hdr1,
	input  logic [7:0]                    ftr0,
	input  logic [7:0]                    ftr1,
	output logic                          frm_valid,
	input  logic                          frm_ready,
	output fsd_pkg::frame_meta_t          frm_meta,
	output logic [PAYLOAD_BYTES*8-1:0]    frm_payload
);
	import fsd_pkg::*;

	localparam int unsigned WIN_LEN   = PAYLOAD_BYTES + 18;
	localparam int unsigned FILL_W    = $clog2(WIN_LEN + 1);
	localparam int unsigned SUM_LEN   = PAYLOAD_BYTES + 12;
	// checksum span parity decides which parity sum the entering byte joins
	localparam int unsigned SPAN_ODD  = SUM_LEN % 2;

	// shift register, newest byte at index WIN_LEN-1
	logic [7:0]        win_q [WIN_LEN];
	logic [FILL_W-1:0] fill_q;
	logic [31:0]       drops_q;
	// byte sums over window positions 2..SUM_LEN+1, split by position parity
	logic [15:0]       ev_q;
	logic [15:0]       od_q;
	logic              full;
	logic              good;
	logic              accept;
	logic [15:0]       n_ev;
	logic [15:0]       n_od;
	logic [15:0]       span_sum;
	logic [7:0]        nb [WIN_LEN];

	// build the window as it will be with the incoming byte, when a test happens
	always_comb begin
		for (int i = 0; i < WIN_LEN - 1; i++) begin
			nb[i] = win_q[i + 1];
		end
		nb[WIN_LEN - 1] = rx_byte;
	end

	assign full   = (fill_q == FILL_W'(WIN_LEN - 1));
	assign accept = in_valid && in_ready;

	// a shift swaps position parity: odd bytes become even, even bytes lose
	// the one leaving the span and gain or pass on the one entering it
	always_comb begin
		if (SPAN_ODD == 1) begin
			n_ev = od_q + {8'h00, nb[SUM_LEN + 1]};
			n_od = ev_q - {8'h00, win_q[2]};
		end else begin
			n_ev = od_q;
			n_od = ev_q - {8'h00, win_q[2]} + {8'h00, nb[SUM_LEN + 1]};
		end
		// even positions are high bytes of the big-endian words
		span_sum = {n_ev[7:0], 8'h00} + n_od;
	end

	assign good = full && nb[0] == hdr0 && nb[1] == hdr1
		&& nb[WIN_LEN - 2] == ftr0 && nb[WIN_LEN - 1] == ftr1
		&& span_sum == {nb[WIN_LEN - 4], nb[WIN_LEN - 3]};

	// stall only while a frame waits in the hand-off register
	assign in_ready = !(frm_valid && !frm_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			drops_q   <= '0;
			ev_q      <= '0;
			od_q      <= '0;
			frm_valid <= 1'b0;
			for (int i = 0; i < WIN_LEN; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (frm_valid && frm_ready) begin
				frm_valid <= 1'b0;
			end
			if (accept) begin
				if (good) begin
					frm_valid <= 1'b1;
					fill_q    <= '0;
					ev_q      <= '0;
					od_q      <= '0;
					for (int i = 0; i < WIN_LEN; i++) begin
						win_q[i] <= '0;
					end
				end else begin
					for (int i = 0; i < WIN_LEN; i++) begin
						win_q[i] <= nb[i];
					end
					ev_q <= n_ev;
					od_q <= n_od;
					if (full) begin
						if (drops_q != '1) begin
							drops_q <= drops_q + 32'd1;
						end
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
			end
		end
	end

	// frame hand-off registers, payload needs no reset
	always_ff @(posedge clk) begin
		if (accept && good) begin
			frm_meta.drops <= drops_q;
			for (int i = 0; i < 4; i++) begin
				frm_meta.seq[31 - 8*i -: 8] <= nb[2 + i];
			end
			for (int i = 0; i < 8; i++) begin
				frm_meta.ts[63 - 8*i -: 8] <= nb[6 + i];
			end
			for (int i = 0; i < PAYLOAD_BYTES; i++) begin
				frm_payload[PAYLOAD_BYTES*8 - 1 - 8*i -: 8] <= nb[HDR_BYTES + i];
			end
		end
	end

endmodule

>>> rtl/core/fsd_chunker.sv
// back end: splits one frame into 64-bit payload chunks
module fsd_chunker #(
	parameter int unsigned PAYLOAD_BYTES = 72
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       frm_valid,
	output logic                       frm_ready,
	input  fsd_pkg::frame_meta_t       frm_meta,
	input  logic [PAYLOAD_BYTES*8-1:0] frm_payload,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [31:0]                sequence_number,
	output logic [63:0]                timestamp_ns,
	output logic [3:0]                 chunk_index,
	output logic [63:0]                payload_chunk,
	output logic                       last_chunk,
	output logic [31:0]                discarded_bytes
);
	import fsd_pkg::*;

	localparam int unsigned NUM_CHUNKS = (PAYLOAD_BYTES + 7) / 8;
	localparam int unsigned PAD_W      = NUM_CHUNKS * 64;
	localparam int unsigned CNT_W      = $clog2(NUM_CHUNKS + 1);

	logic [PAD_W-1:0]  buf_q;
	frame_meta_t       meta_q;
	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              step;

	assign frm_ready = !busy_q;
	assign step      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (frm_valid && frm_ready) begin
				busy_q    <= 1'b1;
				cnt_q     <= '0;
				out_valid <= 1'b1;
			end else if (step) begin
				if (cnt_q == CNT_W'(NUM_CHUNKS - 1)) begin
					busy_q    <= 1'b0;
					out_valid <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frm_valid && frm_ready) begin
			meta_q <= frm_meta;
			// a partial last chunk is padded with zero low bytes
			buf_q  <= PAD_W'(frm_payload) << (PAD_W - PAYLOAD_BYTES*8);
		end else if (step) begin
			buf_q <= buf_q << 64;
		end
	end

	assign sequence_number = meta_q.seq;
	assign timestamp_ns    = meta_q.ts;
	assign discarded_bytes = meta_q.drops;
	assign chunk_index     = 4'(cnt_q);
	assign payload_chunk   = buf_q[PAD_W-1 -: 64];
	assign last_chunk      = (cnt_q == CNT_W'(NUM_CHUNKS - 1));

endmodule

>>> tb/sv/tb_frame_sync_deframer.sv
// testbench for the frame sync deframer: sliding-window predictor and beat checker
`timescale 1ns / 1ps
module tb_frame_sync_deframer;
	import fsd_pkg::*;

	localparam int WIN_LEN   = 90;
	localparam int N_CHUNKS  = 9;
	localparam int WD_LIMIT  = 20000;

	typedef struct {
		logic [31:0] seq;
		logic [63:0] ts;
		logic [3:0]  idx;
		logic [63:0] chunk;
		logic        last;
		logic [31:0] drops;
	} chunk_beat_t;

	logic        clk, arst_n;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid, in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid, out_ready;
	logic [31:0] sequence_number;
	logic [63:0] timestamp_ns;
	logic [3:0]  chunk_index;
	logic [63:0] payload_chunk;
	logic        last_chunk;
	logic [31:0] discarded_bytes;

	frame_sync_deframer dut (.*);

	// predictor state
	logic [7:0]  win [WIN_LEN] = '{default: 8'h00};
	int          fill = 0;
	logic [31:0] drop_cnt = '0;
	logic [7:0]  hdr0, hdr1, ftr0, ftr1;

	logic [7:0]  pend_bytes [$];
	chunk_beat_t exp_chunks [$];
	int mism = 0;
	int bytes_in = 0;
	int chunks_out = 0;
	int frames_built = 0;
	int wd_cnt = 0;
	int burst_left, gap_left;
	logic [31:0] cyc;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic void deframe_byte(logic [7:0] b);
		logic [15:0] sum;
		logic        good;
		logic [31:0] seq;
		logic [63:0] ts;
		chunk_beat_t e;
		if (fill >= WIN_LEN) fill = 0;
		win[fill] = b;
		fill++;
		if (fill < WIN_LEN) return;
		sum = 0;
		for (int k = 2; k < 86; k += 2) sum += {win[k], win[k+1]};
		good = win[0] == hdr0 && win[1] == hdr1 && win[88] == ftr0 && win[89] == ftr1
			&& sum == {win[86], win[87]};
		if (!good) begin
			for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i+1];
			win[WIN_LEN-1] = 0;
			fill = WIN_LEN - 1;
			if (drop_cnt != 32'hFFFF_FFFF) drop_cnt++;
			return;
		end
		seq = {win[2], win[3], win[4], win[5]};
		ts = 0;
		for (int i = 6; i < 14; i++) ts = {ts[55:0], win[i]};
		for (int c = 0; c < N_CHUNKS; c++) begin
			e.seq = seq;
			e.ts = ts;
			e.idx = c[3:0];
			e.chunk = 0;
			for (int i = 0; i < 8; i++) e.chunk = {e.chunk[55:0], win[14 + c*8 + i]};
			e.last = (c == N_CHUNKS - 1);
			e.drops = drop_cnt;
			exp_chunks.push_back(e);
		end
		foreach (win[i]) win[i] = 0;
		fill = 0;
	endfunction

	// builds one frame for the current header/footer; flip_pos >= 0 corrupts one bit
	function automatic void queue_frame(logic [31:0] seq, logic [63:0] ts, logic fill_ones,
			int flip_pos);
		logic [7:0]  f [WIN_LEN];
		logic [15:0] sum;
		f[0] = hdr0;
		f[1] = hdr1;
		for (int i = 0; i < 4; i++) f[2+i] = seq[31-8*i -: 8];
		for (int i = 0; i < 8; i++) f[6+i] = ts[63-8*i -: 8];
		for (int i = 14; i < 86; i++) f[i] = fill_ones ? 8'hFF : 8'($urandom);
		sum = 0;
		for (int k = 2; k < 86; k += 2) sum += {f[k], f[k+1]};
		f[86] = sum[15:8];
		f[87] = sum[7:0];
		f[88] = ftr0;
		f[89] = ftr1;
		if (flip_pos >= 0) f[flip_pos][$urandom_range(0, 7)] ^= 1'b1;
		for (int i = 0; i < WIN_LEN; i++) pend_bytes.push_back(f[i]);
		frames_built++;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [7:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_HEADER_0: hdr0 = v;
			CFG_HEADER_1: hdr1 = v;
			CFG_FOOTER_0: ftr0 = v;
			CFG_FOOTER_1: ftr1 = v;
			default: ;
		endcase
	endtask

	task automatic set_marks(logic [7:0] h0, h1, f0, f1);
		write_reg(CFG_HEADER_0, h0);
		write_reg(CFG_HEADER_1, h1);
		write_reg(CFG_FOOTER_0, f0);
		write_reg(CFG_FOOTER_1, f1);
	endtask

	task automatic drain();
		@(posedge clk);
		while (pend_bytes.size() != 0 || in_valid || exp_chunks.size() != 0) @(posedge clk);
		// bad windows give no beat, so let the front settle
		repeat (16) @(posedge clk);
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!(in_valid && !in_ready)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pend_bytes.size() != 0) begin
				in_valid <= 1'b1;
				rx_byte <= pend_bytes.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 120);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern: free-running, random, dense stalls, then a long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
			case (cyc[8:7])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= 1'($urandom_range(0, 1));
				2'd2: out_ready <= (cyc % 7) > 4;
				default: out_ready <= cyc[6:0] > 100;
			endcase
		end
	end

	// monitor, predictor feed and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				deframe_byte(rx_byte);
				bytes_in++;
			end
			if (out_valid && out_ready) begin
				chunks_out++;
				if (exp_chunks.size() == 0) begin
					mism++;
					if (mism <= 10) $display("unexpected beat: chunk %0d data %h", chunk_index,
						payload_chunk);
				end else begin
					chunk_beat_t e;
					e = exp_chunks.pop_front();
					if (e.seq !== sequence_number || e.ts !== timestamp_ns
							|| e.idx !== chunk_index || e.chunk !== payload_chunk
							|| e.last !== last_chunk || e.drops !== discarded_bytes) begin
						mism++;
						if (mism <= 10) begin
							$display("mismatch exp seq %h ts %h idx %0d chunk %h last %b drops %0d",
								e.seq, e.ts, e.idx, e.chunk, e.last, e.drops);
							$display("         got seq %h ts %h idx %0d chunk %h last %b drops %0d",
								sequence_number, timestamp_ns, chunk_index, payload_chunk,
								last_chunk, discarded_bytes);
						end
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				wd_cnt <= 0;
			else
				wd_cnt <= wd_cnt + 1;
			if (wd_cnt >= WD_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HEADER_0;
		cfg_data = 8'h00;
		hdr0 = 0; hdr1 = 0; ftr0 = 0; ftr1 = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset marks: an all-zero window is a good frame
		for (int i = 0; i < WIN_LEN; i++) pend_bytes.push_back(8'h00);
		drain();

		// all-ones marks and fields, a corrupted frame, stray bytes, then a frame
		// that lands on the other byte alignment
		set_marks(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_frame(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, -1);
		queue_frame(32'h0, 64'h0, 1'b0, $urandom_range(0, WIN_LEN - 1));
		for (int i = 0; i < 5; i++) pend_bytes.push_back(8'($urandom));
		queue_frame(32'h8000_0001, 64'h8000_0000_0000_0001, 1'b0, -1);
		drain();

		// mixed marks with a random lead-in
		set_marks(8'h00, 8'hFF, 8'h00, 8'hFF);
		repeat ($urandom_range(1, 7)) pend_bytes.push_back(8'($urandom));
		queue_frame($urandom, {$urandom, $urandom}, 1'b0, -1);
		drain();

		$display("covered %0d bytes in %0d built frames, %0d chunk beats checked",
			bytes_in, frames_built, chunks_out);
		$display("final discard count %0d, mismatches %0d", drop_cnt, mism);
		if (mism == 0 && exp_chunks.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> frame_sync_deframer.f
rtl/core/fsd_pkg.sv
rtl/core/fsd_window.sv
rtl/core/fsd_chunker.sv
rtl/core/frame_sync_deframer.sv
tb/sv/tb_frame_sync_deframer.sv
